// File: rtl/egbi_pkg.sv
// shared types and constants for the elevation grid bicubic interpolator
package egbi_pkg;

  // stream payload widths
  localparam int S_TDATA_W = 64;
  localparam int M_TDATA_W = 32;
  localparam int OUT_W = 25;

  // configuration port
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;
  localparam logic [CFG_DATA_W-1:0] SIZE_RESET = 9'd256;

  // width of a grid size limit (up to 511)
  localparam int LIM_W = 13;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // void post marker
  localparam logic signed [15:0] VOID_POST = 16'sh8000;

  // output saturation bounds
  localparam int OUT_MAX = 16777215;
  localparam int OUT_MIN = -16777216;

  // controller to datapath commands
  typedef struct packed {
    logic       wr;
    logic       load;
    logic       sq;
    logic       cube;
    logic       wgt;
    logic       rd;
    logic [3:0] step;
    logic       out_load;
  } egbi_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic done;
    logic out_full;
  } egbi_status_t;

endpackage

// File: rtl/egbi_ctrl.sv
// sequencing controller: post writes, weight setup, sixteen post reads, result hand-off
module egbi_ctrl import egbi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tuser,
  output logic         s_tready,
  input  logic         m_tready,
  input  egbi_status_t status,
  output egbi_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SQ    = 3'd1;
  localparam logic [2:0] ST_CUBE  = 3'd2;
  localparam logic [2:0] ST_WGT   = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd6;

  logic [2:0] state, state_next;
  logic [3:0] cnt, cnt_next;

  // state and read counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.step = cnt;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load = 1'b1;
            state_next = ST_SQ;
          end
        end
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        state_next = ST_CUBE;
      end
      ST_CUBE: begin
        cmd.cube = 1'b1;
        state_next = ST_WGT;
      end
      ST_WGT: begin
        cmd.wgt = 1'b1;
        cnt_next = '0;
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd15) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status.done) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (!status.out_full || m_tready) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/egbi_datapath.sv
// post memory, Catmull-Rom weights, multiply-accumulate pipeline, output register
module egbi_datapath import egbi_pkg::*; #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  egbi_cmd_t             cmd,
  output egbi_status_t          status,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [M_TDATA_W-1:0]  m_tdata
);

  localparam int F = FRAC_BITS;
  localparam int WW = F + 3;
  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW = $clog2(DEPTH);
  localparam int QW = 36;
  localparam int PW = WW + 16;
  localparam int SW = PW + 2;
  localparam int CPW = WW + QW;
  localparam int TW = CPW + 2;
  localparam int TSHL = (F >= 16) ? F - 16 : 0;
  localparam int TSHR = (F < 16) ? 16 - F : 0;
  localparam int QSHR = (F >= 15) ? F - 15 : 0;
  localparam int QSHL = (F < 15) ? 15 - F : 0;
  localparam logic [AW-1:0] ROWS_A = AW'(GRID_ROWS);

  // input fields
  logic [7:0] s_col, s_row;
  logic [15:0] s_cfrac, s_rfrac;
  logic signed [15:0] s_post;
  assign s_col = s_tdata[7:0];
  assign s_row = s_tdata[15:8];
  assign s_cfrac = s_tdata[31:16];
  assign s_rfrac = s_tdata[47:32];
  assign s_post = s_tdata[63:48];

  // grid size registers
  logic [CFG_DATA_W-1:0] cols_reg, rows_reg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= SIZE_RESET;
      rows_reg <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COLS: cols_reg <= cfg_data;
        CFG_ROWS: rows_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [LIM_W-1:0] limit_of(input logic [CFG_DATA_W-1:0] r,
                                                input int g);
    if (LIM_W'(r) > LIM_W'(g)) return LIM_W'(g);
    if (r == '0) return LIM_W'(1);
    return LIM_W'(r);
  endfunction

  function automatic logic [LIM_W-1:0] clamp_idx(input logic [7:0] base,
                                                 input logic [1:0] off,
                                                 input logic [LIM_W-1:0] lim);
    logic signed [LIM_W+1:0] i;
    i = $signed({2'b00, LIM_W'(base)}) + $signed((LIM_W+2)'(off))
        - $signed((LIM_W+2)'(1));
    if (i < 0) return '0;
    if (i >= $signed({2'b00, lim})) return lim - LIM_W'(1);
    return i[LIM_W-1:0];
  endfunction

  // twice the Catmull-Rom weight for tap k
  function automatic logic signed [WW-1:0] weight(input logic [1:0] k,
                                                  input logic [F-1:0] t,
                                                  input logic [F-1:0] t2,
                                                  input logic [F-1:0] t3);
    logic signed [WW-1:0] a, b, c, one2;
    a = $signed({3'b000, t});
    b = $signed({3'b000, t2});
    c = $signed({3'b000, t3});
    one2 = $signed(WW'(1)) <<< (F + 1);
    case (k)
      2'd0: return -c + (b <<< 1) - a;
      2'd1: return (c <<< 1) + c - ((b <<< 2) + b) + one2;
      2'd2: return -((c <<< 1) + c) + (b <<< 2) + a;
      default: return c - b;
    endcase
  endfunction

  // query registers
  logic [7:0] q_col, q_row;
  logic [F-1:0] tc, tr, t2c, t2r, t3c, t3r;
  logic signed [WW-1:0] wc [4];
  logic signed [WW-1:0] wr [4];
  logic [F-1:0] mul_ac, mul_ar;
  logic [2*F-1:0] m_c, m_r;

  assign mul_ac = cmd.cube ? t2c : tc;
  assign mul_ar = cmd.cube ? t2r : tr;
  assign m_c = mul_ac * tc;
  assign m_r = mul_ar * tr;

  // fraction scaling, squares, cubes and weights
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_col <= s_col;
      q_row <= s_row;
      tc <= F'(((16 + TSHL)'(s_cfrac) << TSHL) >> TSHR);
      tr <= F'(((16 + TSHL)'(s_rfrac) << TSHL) >> TSHR);
    end
    if (cmd.sq) begin
      t2c <= m_c[2*F-1:F];
      t2r <= m_r[2*F-1:F];
    end
    if (cmd.cube) begin
      t3c <= m_c[2*F-1:F];
      t3r <= m_r[2*F-1:F];
    end
    if (cmd.wgt) begin
      for (int k = 0; k < 4; k++) begin
        wc[k] <= weight(2'(k), tc, t2c, t3c);
        wr[k] <= weight(2'(k), tr, t2r, t3r);
      end
    end
  end

  // write and read addresses
  logic wr_ok;
  logic [AW-1:0] waddr, raddr;
  logic [LIM_W-1:0] clim, rlim, rc, rr;
  assign wr_ok = (LIM_W'(s_col) < LIM_W'(GRID_COLS)) && (LIM_W'(s_row) < LIM_W'(GRID_ROWS));
  assign waddr = AW'(s_col) * ROWS_A + AW'(s_row);
  assign clim = limit_of(cols_reg, GRID_COLS);
  assign rlim = limit_of(rows_reg, GRID_ROWS);
  assign rc = clamp_idx(q_col, cmd.step[3:2], clim);
  assign rr = clamp_idx(q_row, cmd.step[1:0], rlim);
  assign raddr = AW'(rc) * ROWS_A + AW'(rr);

  // post memory, single port
  logic signed [15:0] mem [DEPTH];
  logic signed [15:0] mem_q;
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) mem[waddr] <= s_post;
    if (cmd.rd) mem_q <= mem[raddr];
  end

  // pipeline tags
  logic v1, v2, v4, rdone, done;
  logic [1:0] ri1, ci1, ri2, ci2, ci3, ci4;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      rdone <= 1'b0;
      v4 <= 1'b0;
      done <= 1'b0;
    end else begin
      v1 <= cmd.rd;
      v2 <= v1;
      rdone <= v2 && (ri2 == 2'd3);
      v4 <= rdone;
      done <= v4 && (ci4 == 2'd3);
    end
  end

  // row products, row sums, column products and total
  logic signed [15:0] post_s;
  logic signed [PW-1:0] prod;
  logic signed [SW-1:0] rowsum;
  logic signed [QW-1:0] q16;
  logic signed [CPW-1:0] cprod;
  logic signed [TW-1:0] total;
  assign post_s = (mem_q == VOID_POST) ? 16'sd0 : mem_q;
  assign q16 = QW'(((SW + QSHL)'(rowsum) >>> QSHR) <<< QSHL);

  always_ff @(posedge clk) begin
    ri1 <= cmd.step[1:0];
    ci1 <= cmd.step[3:2];
    ri2 <= ri1;
    ci2 <= ci1;
    prod <= wr[ri1] * post_s;
    if (v2) begin
      if (ri2 == 2'd0) rowsum <= SW'(prod);
      else rowsum <= rowsum + SW'(prod);
    end
    ci3 <= ci2;
    if (rdone) cprod <= wc[ci3] * q16;
    ci4 <= ci3;
    if (v4) begin
      if (ci4 == 2'd0) total <= TW'(cprod);
      else total <= total + TW'(cprod);
    end
  end

  // rounding and saturation
  logic signed [TW-1:0] rnd, res_sh;
  logic [OUT_W-1:0] res;
  assign rnd = total + ($signed(TW'(1)) <<< (F + 8));
  assign res_sh = rnd >>> (F + 9);
  always_comb begin
    if (res_sh > TW'(OUT_MAX)) res = OUT_W'(OUT_MAX);
    else if (res_sh < TW'(OUT_MIN)) res = OUT_W'(OUT_MIN);
    else res = res_sh[OUT_W-1:0];
  end

  // output register
  logic [OUT_W-1:0] out_data;
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (cmd.out_load) out_data <= res;
  end

  assign m_tdata = {{(M_TDATA_W - OUT_W){1'b0}}, out_data};
  assign status.done = done;
  assign status.out_full = m_tvalid;

endmodule

// File: rtl/elevation_grid_bicubic_interp_top.sv
// top level of the elevation grid bicubic interpolator
//
// Input stream s_*: tuser selects the item kind (0 writes a post, 1 queries).
// A write transfer stores post_value at (col_index, row_index), and the
// block stays ready for the next item. A query reads the 4x4 neighborhood
// around the point, clamped to cols_in_use/rows_in_use, and returns one
// elevation in 1/256 m on m_*.
// A query runs from input transfer to m_tvalid through weight setup (square,
// cube, weights), 16 reads of the single-port post memory (one per cycle),
// the multiply-accumulate pipeline (prod, rowsum, cprod, total) and the
// load of the output register. One query is in flight at a time, and no
// new item is taken before it ends; writes sustain one per cycle while idle.
// The result waits in an output register; a new item is taken while it
// waits, and a following query holds at its end until the register drains.
// Reset (rst, synchronous) clears control state and sets both grid sizes to 256; the post
// memory is not cleared and must be written before read. Configuration writes (cfg_we,
// cfg_index, cfg_data) are the user's to make only while idle; the block does not check.
module elevation_grid_bicubic_interp_top import egbi_pkg::*; #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // col_index[7:0], row_index[15:8], col_fraction[31:16],
  // row_fraction[47:32], post_value[63:48]
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // op
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // elevation_q8[24:0], zero above
  output logic [M_TDATA_W-1:0]  m_tdata
);

  egbi_cmd_t    cmd;
  egbi_status_t status;

  egbi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  egbi_datapath #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

// File: rtl/egbi_checker.sv
// port-level checks of the interpolator, bound to the top level
module egbi_port_checker import egbi_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a new result appears only while a query is being finished
  a_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without a query in progress");

  // padding bits above the result stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_TDATA_W-1:OUT_W] == '0)
    else $error("nonzero padding in result");

endmodule

bind elevation_grid_bicubic_interp_top egbi_port_checker u_egbi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: dv/egbi_checker.sv
// checker for the elevation grid interpolator: predicts query results and compares them
module egbi_checker import egbi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [M_TDATA_W-1:0]  m_tdata,
  output int                    pending,
  output int                    errors
);

  // own copy of the grid and the size registers
  logic signed [15:0] grid_posts [0:65535];
  logic [CFG_DATA_W-1:0] cols_reg;
  logic [CFG_DATA_W-1:0] rows_reg;
  logic signed [OUT_W-1:0] elev_expect [$];

  function automatic int size_limit(logic [CFG_DATA_W-1:0] r);
    if (r > 9'd256) return 256;
    if (r == '0) return 1;
    return int'(r);
  endfunction

  function automatic int clamp_to(int i, int lim);
    if (i < 0) return 0;
    if (i >= lim) return lim - 1;
    return i;
  endfunction

  // twice the catmull-rom weight k for fraction t, q16
  function automatic longint cr_weight(longint t, int k);
    longint t2;
    longint t3;
    t2 = (t * t) >>> 16;
    t3 = (t2 * t) >>> 16;
    case (k)
      0: return -t3 + 2 * t2 - t;
      1: return 3 * t3 - 5 * t2 + (longint'(1) << 17);
      2: return -3 * t3 + 4 * t2 + t;
      default: return t3 - t2;
    endcase
  endfunction

  // bicubic sum over the clamped 4x4 neighborhood
  function automatic logic signed [OUT_W-1:0] interp_elev(int col, int row,
                                                          longint cf, longint rf);
    int clim;
    int rlim;
    int c;
    int r;
    longint total;
    longint rsum;
    longint pv;
    longint res;
    clim = size_limit(cols_reg);
    rlim = size_limit(rows_reg);
    total = 0;
    for (int ci = 0; ci < 4; ci++) begin
      c = clamp_to(col + ci - 1, clim);
      rsum = 0;
      for (int ri = 0; ri < 4; ri++) begin
        r = clamp_to(row + ri - 1, rlim);
        pv = (grid_posts[c * 256 + r] == VOID_POST) ? 0 : longint'(grid_posts[c * 256 + r]);
        rsum += cr_weight(rf, ri) * pv;
      end
      total += cr_weight(cf, ci) * (rsum >>> 1);
    end
    res = (total + (longint'(1) << 24)) >>> 25;
    if (res > OUT_MAX) res = OUT_MAX;
    if (res < OUT_MIN) res = OUT_MIN;
    return res[OUT_W-1:0];
  endfunction

  assign pending = elev_expect.size();

  // track config, input transfers and result transfers
  always @(posedge clk) begin
    if (rst) begin
      cols_reg <= SIZE_RESET;
      rows_reg <= SIZE_RESET;
      elev_expect.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COLS) cols_reg <= cfg_data;
        else if (cfg_index == CFG_ROWS) rows_reg <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == OP_WRITE)
          grid_posts[{s_tdata[7:0], s_tdata[15:8]}] = s_tdata[63:48];
        else
          elev_expect.push_back(interp_elev(int'(s_tdata[7:0]), int'(s_tdata[15:8]),
                                            longint'(s_tdata[31:16]),
                                            longint'(s_tdata[47:32])));
      end
      if (m_tvalid && m_tready) begin
        if (elev_expect.size() == 0) begin
          $error("unexpected result transfer elevation_q8=%0d",
                 $signed(m_tdata[OUT_W-1:0]));
          errors <= errors + 1;
        end else begin
          if (m_tdata[OUT_W-1:0] !== elev_expect[0]) begin
            $error("elevation_q8 mismatch: expected %0d actual %0d",
                   elev_expect[0], $signed(m_tdata[OUT_W-1:0]));
            errors <= errors + 1;
          end
          void'(elev_expect.pop_front());
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
// top of the interpolator testbench: stimulus, idling and verdict
module tb_top;
  import egbi_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_COLS;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic s_tuser = OP_WRITE;
  logic m_tvalid;
  logic m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;
  int pending;
  int errors;

  // tb side view of what has been written and the sizes in use
  bit written [0:65535];
  int clim = 256;
  int rlim = 256;
  int item_count = 0;
  bit idle_on = 1'b1;

  always #10 clk = ~clk;

  elevation_grid_bicubic_interp_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  egbi_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .pending(pending), .errors(errors)
  );

  // result side stalls in bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_tready = 1'b1;
    end
  end

  function automatic int size_limit(int r);
    if (r > 256) return 256;
    if (r == 0) return 1;
    return r;
  endfunction

  function automatic int clamp_to(int i, int lim);
    if (i < 0) return 0;
    if (i >= lim) return lim - 1;
    return i;
  endfunction

  // one input transfer, with an optional sender gap in front
  task automatic send_item(logic op, logic [7:0] col, logic [7:0] row,
                           logic [15:0] cf, logic [15:0] rf, logic [15:0] pv);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = op;
    s_tdata = {pv, rf, cf, row, col};
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    if (op == OP_WRITE) written[{col, row}] = 1'b1;
    item_count++;
  endtask

  task automatic write_post(int col, int row, logic [15:0] pv);
    send_item(OP_WRITE, col[7:0], row[7:0], 16'($urandom), 16'($urandom), pv);
  endtask

  // write any neighbor not yet written, then send the query
  task automatic query_at(int col, int row, logic [15:0] cf, logic [15:0] rf);
    int c;
    int r;
    for (int ci = -1; ci <= 2; ci++) begin
      for (int ri = -1; ri <= 2; ri++) begin
        c = clamp_to(col + ci, clim);
        r = clamp_to(row + ri, rlim);
        if (!written[c * 256 + r]) write_post(c, r, 16'($urandom));
      end
    end
    send_item(OP_QUERY, col[7:0], row[7:0], cf, rf, 16'($urandom));
  endtask

  // drain all results, let the pipeline settle, then write both sizes
  task automatic set_sizes(int cols, int rows);
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_COLS;
    cfg_data = cols[8:0];
    @(negedge clk);
    cfg_index = CFG_ROWS;
    cfg_data = rows[8:0];
    @(negedge clk);
    cfg_we = 1'b0;
    clim = size_limit(cols);
    rlim = size_limit(rows);
  endtask

  // random mix: mostly queries near written spots, some stray writes
  task automatic random_phase(int n);
    int base_c;
    int base_r;
    int stop;
    stop = item_count + n;
    base_c = $urandom_range(0, 255);
    base_r = $urandom_range(0, 255);
    while (item_count < stop) begin
      case ($urandom_range(0, 9))
        0, 1: write_post($urandom_range(0, 255), $urandom_range(0, 255), 16'($urandom));
        2: write_post(base_c + $urandom_range(0, 3), base_r + $urandom_range(0, 3),
                      ($urandom_range(0, 3) == 0) ? VOID_POST : 16'($urandom));
        3: query_at($urandom_range(0, 255), $urandom_range(0, 255),
                    16'($urandom), 16'($urandom));
        4: begin
          base_c = $urandom_range(0, 255);
          base_r = $urandom_range(0, 255);
        end
        default: query_at((base_c + $urandom_range(0, 5)) % 256,
                          (base_r + $urandom_range(0, 5)) % 256,
                          16'($urandom), 16'($urandom));
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: post extremes, void, fraction extremes, grid corners
    write_post(10, 10, 16'sh7FFF);
    write_post(11, 10, VOID_POST);
    write_post(10, 11, 16'sh8001);
    write_post(11, 11, 16'h0000);
    query_at(10, 10, 16'h0000, 16'h0000);
    query_at(10, 10, 16'hFFFF, 16'hFFFF);
    query_at(10, 10, 16'h8000, 16'h0001);
    query_at(0, 0, 16'hFFFF, 16'h0000);
    query_at(255, 255, 16'h0000, 16'hFFFF);
    query_at(0, 255, 16'h8000, 16'h8000);
    query_at(255, 0, 16'h4000, 16'hC000);

    // small grid with the query point beyond the size in use
    set_sizes(4, 4);
    query_at(3, 3, 16'hFFFF, 16'hFFFF);
    query_at(200, 100, 16'h1234, 16'hABCD);
    query_at(0, 0, 16'h0000, 16'h0000);
    random_phase(200);

    // out of range sizes: zero acts as one, above the grid acts as the grid
    set_sizes(0, 511);
    query_at(5, 250, 16'h7FFF, 16'h8000);
    random_phase(150);
    set_sizes(300, 17);
    random_phase(200);
    set_sizes(256, 4);
    random_phase(200);
    set_sizes(256, 256);
    random_phase(200);

    // last stretch with no idling on either side
    set_sizes(37, 200);
    idle_on = 1'b0;
    random_phase(180);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/egbi_pkg.sv
rtl/egbi_ctrl.sv
rtl/egbi_datapath.sv
rtl/elevation_grid_bicubic_interp_top.sv
rtl/egbi_checker.sv
dv/egbi_checker.sv
dv/tb_top.sv
